### hw/rtl/mdw_pkg.sv
// Shared types and constants for the maximum-sum distinct-window block.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package mdw_pkg;

    localparam int SUM_BITS     = 21;
    localparam int OUT_SUM_BITS = 20;
    localparam int LEN_BITS     = 11;

    typedef struct packed {
        logic accept;
        logic clear;
        logic evict;
        logic append;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic present;
        logic match;
        logic count_zero;
        logic count_one;
        logic clear_last;
        logic out_busy;
        logic last;
    } status_t;

endpackage

`default_nettype wire

### hw/rtl/max_sum_distinct_window.sv
// Top level of the maximum-sum distinct-window block: controller plus datapath.
// Depends on mdw_pkg, mdw_ctrl, mdw_dp and mdw_ram.
//
//   Channel  Handshake            Payload
//   input    in_valid / in_ready  value, last_item
//   output   out_valid / out_ready best_sum, window_sum, window_length, sequence_done
//
// An item whose value is already in the window first evicts elements from the
// window; the eviction loop retires one element per cycle through the window RAM read port.
// An item marked last is followed by a drain that empties the window.
// After reset a clearing pass writes all 2^VALUE_BITS entries of the presence RAM
// before the first request is accepted.
// A result waits in the output register; only the next result stalls behind it.
`timescale 1ns / 1ps
`default_nettype none

module max_sum_distinct_window #(
    parameter int VALUE_BITS = 10
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [VALUE_BITS-1:0]             value,
    input  wire logic                              last_item,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [mdw_pkg::OUT_SUM_BITS-1:0]       best_sum,
    output logic [mdw_pkg::OUT_SUM_BITS-1:0]       window_sum,
    output logic [mdw_pkg::LEN_BITS-1:0]           window_length,
    output logic                                   sequence_done
);

    mdw_pkg::cmd_t    cmd;
    mdw_pkg::status_t status;

    mdw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    mdw_dp #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .value         (value),
        .last_item     (last_item),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .best_sum      (best_sum),
        .window_sum    (window_sum),
        .window_length (window_length),
        .sequence_done (sequence_done)
    );

endmodule

`default_nettype wire

### hw/rtl/mdw_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.
`timescale 1ns / 1ps
`default_nettype none

module mdw_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/mdw_ctrl.sv
// Controller state machine: sequences clearing, eviction, append and drain.
// Depends on mdw_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module mdw_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire mdw_pkg::status_t status,
    output mdw_pkg::cmd_t        cmd
);

    localparam logic [2:0] ST_CLEAR       = 3'd0;
    localparam logic [2:0] ST_IDLE        = 3'd1;
    localparam logic [2:0] ST_CHECK       = 3'd2;
    localparam logic [2:0] ST_EVICT       = 3'd3;
    localparam logic [2:0] ST_APPEND      = 3'd4;
    localparam logic [2:0] ST_DRAIN_START = 3'd5;
    localparam logic [2:0] ST_DRAIN       = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.present && !status.count_zero)
                begin
                    state_next = ST_EVICT;
                end
                else
                begin
                    state_next = ST_APPEND;
                end
            end
            ST_EVICT:
            begin
                cmd.evict = 1'b1;
                if (status.match || status.count_one)
                begin
                    state_next = ST_APPEND;
                end
            end
            ST_APPEND:
            begin
                if (!status.out_busy)
                begin
                    cmd.append = 1'b1;
                    state_next = status.last ? ST_DRAIN_START : ST_IDLE;
                end
            end
            ST_DRAIN_START:
            begin
                if (status.count_zero)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                cmd.evict = 1'b1;
                if (status.count_one)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/mdw_dp.sv
// Datapath: presence and window memories, pointers, count, sums and result register.
// Depends on mdw_pkg and mdw_ram.
`timescale 1ns / 1ps
`default_nettype none

module mdw_dp #(
    parameter int VALUE_BITS = 10
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire mdw_pkg::cmd_t                     cmd,
    output mdw_pkg::status_t                       status,
    input  wire logic [VALUE_BITS-1:0]             value,
    input  wire logic                              last_item,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [mdw_pkg::OUT_SUM_BITS-1:0]       best_sum,
    output logic [mdw_pkg::OUT_SUM_BITS-1:0]       window_sum,
    output logic [mdw_pkg::LEN_BITS-1:0]           window_length,
    output logic                                   sequence_done
);

    localparam int DEPTH = 1 << VALUE_BITS;

    logic [VALUE_BITS-1:0]            v_reg;
    logic                             last_reg;
    logic [VALUE_BITS-1:0]            head_reg;
    logic [VALUE_BITS-1:0]            head_next;
    logic [VALUE_BITS-1:0]            tail_reg;
    logic [VALUE_BITS-1:0]            tail_next;
    logic [VALUE_BITS-1:0]            clr_reg;
    logic [VALUE_BITS-1:0]            clr_next;
    logic [mdw_pkg::LEN_BITS-1:0]     count_reg;
    logic [mdw_pkg::LEN_BITS-1:0]     count_next;
    logic [mdw_pkg::SUM_BITS-1:0]     sum_reg;
    logic [mdw_pkg::SUM_BITS-1:0]     sum_next;
    logic [mdw_pkg::SUM_BITS-1:0]     best_reg;
    logic [mdw_pkg::SUM_BITS-1:0]     best_next;
    logic [mdw_pkg::SUM_BITS-1:0]     sum_add;
    logic [mdw_pkg::SUM_BITS-1:0]     best_add;
    logic [mdw_pkg::LEN_BITS-1:0]     count_add;
    logic                             out_valid_reg;
    logic                             out_valid_next;

    logic                             pres_wr_en;
    logic [VALUE_BITS-1:0]            pres_wr_addr;
    logic [0:0]                       pres_wr_data;
    logic [0:0]                       pres_rd_data;
    logic [VALUE_BITS-1:0]            buf_rd_data;

    assign pres_wr_en   = cmd.clear || cmd.evict || cmd.append;
    assign pres_wr_addr = cmd.clear ? clr_reg : (cmd.evict ? buf_rd_data : v_reg);
    assign pres_wr_data = cmd.append;

    mdw_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_present (
        .clk     (clk),
        .wr_en   (pres_wr_en),
        .wr_addr (pres_wr_addr),
        .wr_data (pres_wr_data),
        .rd_en   (cmd.accept),
        .rd_addr (value),
        .rd_data (pres_rd_data)
    );

    mdw_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (DEPTH)
    ) u_window (
        .clk     (clk),
        .wr_en   (cmd.append),
        .wr_addr (head_reg),
        .wr_data (v_reg),
        .rd_en   (1'b1),
        .rd_addr (tail_next),
        .rd_data (buf_rd_data)
    );

    assign sum_add   = sum_reg + {{(mdw_pkg::SUM_BITS-VALUE_BITS){1'b0}}, v_reg};
    assign best_add  = (sum_add > best_reg) ? sum_add : best_reg;
    assign count_add = count_reg + 1'b1;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        best_next  = best_reg;
        clr_next   = clr_reg;
        if (cmd.clear)
        begin
            clr_next = clr_reg + 1'b1;
        end
        if (cmd.evict)
        begin
            tail_next  = tail_reg + 1'b1;
            count_next = count_reg - 1'b1;
            sum_next   = sum_reg - {{(mdw_pkg::SUM_BITS-VALUE_BITS){1'b0}}, buf_rd_data};
        end
        if (cmd.append)
        begin
            head_next  = head_reg + 1'b1;
            count_next = count_add;
            sum_next   = sum_add;
            best_next  = best_add;
        end
        if (cmd.finish)
        begin
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
            sum_next   = '0;
            best_next  = '0;
        end
    end

    always_comb
    begin
        if (cmd.append)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
            best_reg      <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            best_reg      <= best_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            v_reg    <= value;
            last_reg <= last_item;
        end
        if (cmd.append)
        begin
            best_sum      <= best_add[mdw_pkg::OUT_SUM_BITS-1:0];
            window_sum    <= sum_add[mdw_pkg::OUT_SUM_BITS-1:0];
            window_length <= count_add;
            sequence_done <= last_reg;
        end
    end

    assign out_valid = out_valid_reg;

    assign status.present    = pres_rd_data[0];
    assign status.match      = (buf_rd_data == v_reg);
    assign status.count_zero = (count_reg == '0);
    assign status.count_one  = (count_reg == mdw_pkg::LEN_BITS'(1));
    assign status.clear_last = (clr_reg == {VALUE_BITS{1'b1}});
    assign status.out_busy   = out_valid_reg && !out_ready;
    assign status.last       = last_reg;

endmodule

`default_nettype wire

### hw/rtl/mdw_checker.sv
// Port-level checks for the maximum-sum distinct-window block, bound to its top level.
// Depends on mdw_pkg for the result widths.
`timescale 1ns / 1ps
`default_nettype none

module mdw_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              in_valid,
    input wire logic                              in_ready,
    input wire logic                              out_valid,
    input wire logic                              out_ready,
    input wire logic [mdw_pkg::OUT_SUM_BITS-1:0]  best_sum,
    input wire logic [mdw_pkg::OUT_SUM_BITS-1:0]  window_sum,
    input wire logic [mdw_pkg::LEN_BITS-1:0]      window_length,
    input wire logic                              sequence_done
);

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid)
        else $error("Input request withdrawn before acceptance.");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(best_sum) && $stable(window_sum)
            && $stable(window_length) && $stable(sequence_done))
        else $error("Stalled result changed or was dropped.");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("A second request was taken while one is still in work.");

    a_best_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> window_sum <= best_sum)
        else $error("Window sum exceeds the best sum reported with it.");

endmodule

bind max_sum_distinct_window mdw_checker u_mdw_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .best_sum      (best_sum),
    .window_sum    (window_sum),
    .window_length (window_length),
    .sequence_done (sequence_done)
);

`default_nettype wire
